/* rtl/next_fit_block_allocator_defines.svh */
// ----------------------------------------------------------------------------
// Next-fit block allocator: assertion macros
// Shared property wrappers. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define NFBA_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("nfba: same-cycle check failed");

// next-cycle implication
`define NFBA_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("nfba: next-cycle check failed");

`endif

/* rtl/nfba_pkg.sv */
// ----------------------------------------------------------------------------
// Next-fit block allocator package
// Widths, operation codes, sequencer states and the space-table write bundle.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int SIZE_WIDTH = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_ALLOC = 2'd1,
		FN_READ  = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  en;
		logic [IDX_W-1:0]      addr;
		logic [SIZE_WIDTH-1:0] data;
	} ram_wr_t;

endpackage

/* rtl/nfba_space_ram.sv */
// ----------------------------------------------------------------------------
// Space table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nfba_space_ram (
	input  logic                           clk,
	input  nfba_pkg::ram_wr_t              wr,
	input  logic [nfba_pkg::IDX_W-1:0]     rd_addr,
	output logic [nfba_pkg::SIZE_WIDTH-1:0] rd_data
);
	import nfba_pkg::*;

	logic [SIZE_WIDTH-1:0] mem_q [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/next_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// Next-fit block allocator
// Keeps remaining space per block and a search cursor; allocates by a
// circular first-fit scan starting at the cursor.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_*      | in        | s_tvalid / s_tready  | tuser func, tdata index+amount
//  m_*      | out       | m_tvalid / m_tready  | tuser placed, tdata block+space
//  cfg_*    | in        | cfg_valid / cfg_ready| block_count
//
//  Load and unused items go from idle to done, read passes a read state,
//  allocate a scan state with one table read and one compare per cycle
//  through the shared compare/subtract unit (no scan with no blocks in use).
//  Input is taken only in idle; a finished result waits in the output
//  register while the block returns to idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "next_fit_block_allocator_defines.svh"

module next_fit_block_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [nfba_pkg::IN_DATA_W-1:0]    s_tdata,  // block_index[3:0], amount[19:4], zero
	input  logic [1:0]                        s_tuser,  // func[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [nfba_pkg::OUT_DATA_W-1:0]   m_tdata,  // chosen_block[3:0], space_left[19:4], zero
	output logic                              m_tuser,  // placed[0]
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nfba_pkg::CNT_W-1:0]        cfg_data
);
	import nfba_pkg::*;

	state_t                state_q, state_nxt;
	func_t                 func_in;
	logic [IDX_W-1:0]      idx_in;
	logic [SIZE_WIDTH-1:0] amt_in;
	logic                  s_xfer, idx_ok;

	logic [CNT_W-1:0]      count_q, used;
	logic [IDX_W-1:0]      cursor_q, start_ptr;
	logic [IDX_W-1:0]      ptr_q, ptr_next;
	logic [CNT_W-1:0]      tried_q, n_q;
	logic [SIZE_WIDTH-1:0] amt_q;
	logic                  hit, last_try;
	logic [SIZE_WIDTH-1:0] diff;

	logic                  res_placed_q;
	logic [IDX_W-1:0]      res_block_q;
	logic [SIZE_WIDTH-1:0] res_left_q;
	logic                  slot_free;

	ram_wr_t               wr;
	logic [IDX_W-1:0]      rd_addr;
	logic [SIZE_WIDTH-1:0] rd_data;

	logic                  m_tvalid_q, m_tuser_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	function automatic logic idx_ok_q(input logic [IDX_W-1:0] idx);
		return {1'b0, idx} < CNT_W'(MAX_BLOCKS);
	endfunction

	nfba_space_ram u_space (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign func_in   = func_t'(s_tuser);
	assign idx_in    = s_tdata[IDX_W-1:0];
	assign amt_in    = s_tdata[IDX_W +: SIZE_WIDTH];
	assign s_xfer    = s_tvalid && s_tready;
	assign idx_ok    = {1'b0, idx_in} < CNT_W'(MAX_BLOCKS);
	assign cfg_ready = 1'b1;

	assign used      = (count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_q;
	assign start_ptr = ({1'b0, cursor_q} < used) ? cursor_q : '0;

	// shared compare/subtract on the entry read last cycle
	assign hit      = rd_data >= amt_q;
	assign diff     = rd_data - amt_q;
	assign ptr_next = (({1'b0, ptr_q} + CNT_W'(1)) == n_q) ? '0 : ptr_q + IDX_W'(1);
	assign last_try = (tried_q + CNT_W'(1)) == n_q;

	assign slot_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_xfer) begin
					unique case (func_in)
						FN_ALLOC: state_nxt = (used == '0) ? ST_DONE : ST_SCAN;
						FN_READ:  state_nxt = ST_READ;
						default:  state_nxt = ST_DONE;
					endcase
				end
			end
			ST_READ: state_nxt = ST_DONE;
			ST_SCAN: begin
				if (hit || last_try) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_addr  = ptr_next;
		wr       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				rd_addr  = (func_in == FN_READ) ? idx_in : start_ptr;
				if (s_xfer && func_in == FN_LOAD && idx_ok) begin
					wr.en   = 1'b1;
					wr.addr = idx_in;
					wr.data = amt_in;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					wr.en   = 1'b1;
					wr.addr = ptr_q;
					wr.data = diff;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			cursor_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (state_q == ST_IDLE && s_xfer && func_in == FN_LOAD && idx_ok) begin
				cursor_q <= '0;
			end else if (state_q == ST_SCAN && hit) begin
				cursor_q <= ptr_next;
			end
			if (state_q == ST_DONE && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_xfer) begin
					amt_q        <= amt_in;
					n_q          <= used;
					ptr_q        <= start_ptr;
					tried_q      <= '0;
					res_placed_q <= 1'b0;
					res_left_q   <= '0;
					res_block_q  <= (func_in == FN_LOAD || func_in == FN_READ) ? idx_in : '0;
				end
			end
			ST_READ: begin
				res_left_q <= idx_ok_q(res_block_q) ? rd_data : '0;
			end
			ST_SCAN: begin
				if (hit) begin
					res_placed_q <= 1'b1;
					res_block_q  <= ptr_q;
					res_left_q   <= diff;
				end else begin
					ptr_q   <= ptr_next;
					tried_q <= tried_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					m_tuser_q <= res_placed_q;
					m_tdata_q <= OUT_DATA_W'({res_left_q, res_block_q});
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`NFBA_ASSERT_NOW(a_scan_ptr_in_range, state_q == ST_SCAN, ({1'b0, ptr_q} < n_q))
	`NFBA_ASSERT_NOW(a_scan_tries_bounded, state_q == ST_SCAN, tried_q < n_q)
	`NFBA_ASSERT_NEXT(a_alloc_starts_scan, s_xfer && func_in == FN_ALLOC && used != '0, state_q == ST_SCAN)

endmodule
